>>> rtl/swar_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package swar_pkg;

    // model size
    localparam int ORDER      = 8;
    localparam int MAX_WINDOW = 1024;
    localparam int HIST_AW    = $clog2(MAX_WINDOW);

    // field and datapath widths
    localparam int WIN_W     = 11;
    localparam int SAMPLE_W  = 16;
    localparam int LAG_W     = 43;
    localparam int R_W       = 31;
    localparam int COEF_W    = 24;
    localparam int IDX_W     = 5;
    localparam int NUM_W     = 58;
    localparam int Q16       = 16;
    localparam int MAG_LIM_W = 30;
    localparam int SHIFT_W   = $clog2(LAG_W - MAG_LIM_W + 1);
    localparam int DIV_CW    = $clog2(NUM_W + 1);
    localparam int LAG_IW    = $clog2(ORDER + 1);
    localparam int COEF_IW   = (ORDER > 1) ? $clog2(ORDER) : 1;

    localparam logic [WIN_W-1:0] WIN_RESET = 11'd256;
    localparam logic [WIN_W-1:0] WIN_MIN   = 11'd2;
    localparam logic [WIN_W-1:0] WIN_MAX   = WIN_W'(MAX_WINDOW);

    // register index of the configuration port
    localparam logic REG_WINDOW = 1'b0;

    // sample word from front to back
    typedef struct packed {
        logic                       valid;
        logic signed [SAMPLE_W-1:0] sample;
    } swar_item_t;

    // back status seen by the front
    typedef struct packed {
        logic take;
        logic clearing;
    } swar_back_stat_t;

    // divider request and response
    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] mag;
        logic [R_W-1:0]   den;
    } swar_div_req_t;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quo;
    } swar_div_rsp_t;

endpackage

`default_nettype wire

>>> rtl/swar_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module swar_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> rtl/swar_div.sv
`timescale 1ns / 1ps
`default_nettype none

module swar_div
    import swar_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire swar_div_req_t req,
    output swar_div_rsp_t      rsp
);

    logic [R_W-1:0]    rem_reg, rem_next;
    logic [NUM_W-1:0]  quo_reg, quo_next;
    logic [R_W-1:0]    den_reg, den_next;
    logic [DIV_CW-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [R_W:0]      trial;
    logic [R_W:0]      diff;

    // one quotient bit per cycle, restoring
    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = '0;
            quo_next  = req.mag;
            den_next  = req.den;
            cnt_next  = DIV_CW'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[R_W])
            begin
                rem_next = diff[R_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[R_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

`default_nettype wire

>>> rtl/swar_front.sv
`timescale 1ns / 1ps
`default_nettype none

module swar_front
    import swar_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       push,
    input  wire logic signed [SAMPLE_W-1:0] sample,
    output logic                            full,
    output swar_item_t                      item,
    input  wire swar_back_stat_t            stat
);

    logic signed [SAMPLE_W-1:0] buf_reg [2];
    logic [1:0]                 cnt_reg, cnt_next;
    logic                       wptr_reg, rptr_reg;
    logic                       wr, rd;

    // two-word sample queue, closed while the history is cleared
    assign full = (cnt_reg == 2'd2) || stat.clearing;
    assign wr   = push && !full;
    assign rd   = stat.take && (cnt_reg != 2'd0);

    assign item.valid  = (cnt_reg != 2'd0) && !stat.clearing;
    assign item.sample = buf_reg[rptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        case ({wr, rd})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (wr)
            begin
                wptr_reg <= !wptr_reg;
            end
            if (rd)
            begin
                rptr_reg <= !rptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            buf_reg[wptr_reg] <= sample;
        end
    end

endmodule

`default_nettype wire

>>> rtl/swar_back.sv
`timescale 1ns / 1ps
`default_nettype none

module swar_back
    import swar_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire swar_item_t               item,
    output swar_back_stat_t               stat,
    input  wire logic [WIN_W-1:0]         window,
    input  wire logic                     pop,
    output logic                          ovalid,
    output logic signed [COEF_W-1:0]      coefficient,
    output logic [IDX_W-1:0]              coefficient_index,
    output logic                          last,
    output logic                          singular
);

    typedef enum logic [19:0] {
        S_CLEAR = 20'h00001,
        S_IDLE  = 20'h00002,
        S_ISSUE = 20'h00004,
        S_CAPT  = 20'h00008,
        S_LAG   = 20'h00010,
        S_WRITE = 20'h00020,
        S_MAG   = 20'h00040,
        S_SHIFT = 20'h00080,
        S_INIT  = 20'h00100,
        S_CHK   = 20'h00200,
        S_NMUL  = 20'h00400,
        S_NACC  = 20'h00800,
        S_DIVGO = 20'h01000,
        S_DIVW  = 20'h02000,
        S_UMUL  = 20'h04000,
        S_USUB  = 20'h08000,
        S_ASET  = 20'h10000,
        S_E1    = 20'h20000,
        S_E2    = 20'h40000,
        S_OUT   = 20'h80000
    } state_t;

    typedef enum logic [2:0] {
        P_LEAVE = 3'b001,
        P_BACK  = 3'b010,
        P_OTHER = 3'b100
    } phase_t;

    localparam logic [LAG_W-1:0] MAG_LIMIT = LAG_W'(1) << MAG_LIM_W;
    localparam logic signed [COEF_W-1:0] Q16_ONE = COEF_W'(1) << Q16;
    localparam logic signed [COEF_W-1:0] SAT_POS = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic signed [COEF_W-1:0] SAT_NEG = {1'b1, {(COEF_W-1){1'b0}}};
    localparam int UP_W = 2 * COEF_W;
    localparam int EP_W = R_W + 32;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;

    logic [HIST_AW-1:0]         clr_reg, clr_next;
    logic [HIST_AW-1:0]         newest_reg, newest_next;
    logic [HIST_AW-1:0]         slot_reg, slot_next;
    logic [WIN_W-1:0]           w_reg, w_next;
    logic signed [SAMPLE_W-1:0] y_reg, y_next;
    logic signed [SAMPLE_W-1:0] leave_reg, leave_next;
    logic signed [SAMPLE_W-1:0] back_reg, back_next;
    logic signed [SAMPLE_W-1:0] other_reg, other_next;
    logic [LAG_IW-1:0]          k_reg, k_next;
    logic [LAG_W-1:0]           lag_reg [ORDER+1];
    logic [LAG_W-1:0]           lag_next [ORDER+1];
    logic [LAG_W-1:0]           mag_reg, mag_next;
    logic [SHIFT_W-1:0]         s_reg, s_next;
    logic signed [R_W-1:0]      e_reg, e_next;
    logic [LAG_IW-1:0]          m_reg, m_next;
    logic [LAG_IW-1:0]          j_reg, j_next;
    logic signed [NUM_W-1:0]    num_reg, num_next;
    logic signed [COEF_W+R_W-1:0] prod_reg, prod_next;
    logic signed [COEF_W-1:0]   kk_reg, kk_next;
    logic signed [COEF_W-1:0]   a_reg [ORDER];
    logic signed [COEF_W-1:0]   a_next [ORDER];
    logic signed [COEF_W-1:0]   prev_reg [ORDER];
    logic signed [COEF_W-1:0]   prev_next [ORDER];
    logic signed [UP_W-1:0]     uprod_reg, uprod_next;
    logic [31:0]                k2_reg, k2_next;
    logic [EP_W-1:0]            ep_reg, ep_next;
    logic                       sing_reg, sing_next;
    logic [LAG_IW-1:0]          oj_reg, oj_next;

    logic                       ovalid_reg, ovalid_next;
    logic signed [COEF_W-1:0]   ocoef_reg, ocoef_next;
    logic [IDX_W-1:0]           oidx_reg, oidx_next;
    logic                       olast_reg, olast_next;
    logic                       osing_reg, osing_next;

    logic                       ram_we;
    logic [HIST_AW-1:0]         ram_waddr, ram_raddr;
    logic [SAMPLE_W-1:0]        ram_wdata, ram_rdata;

    logic [LAG_IW-1:0]          lag_idx;
    logic [LAG_W-1:0]           lag_rd;
    logic signed [R_W-1:0]      r_cur;
    logic [COEF_IW-1:0]         a_idx, p_idx;
    logic signed [COEF_W-1:0]   a_rd;
    logic signed [31:0]         p_new, p_old;
    logic [LAG_W-1:0]           lag_abs;
    logic signed [UP_W-1:0]     up_trunc;
    logic signed [32:0]         upd_diff;
    logic signed [COEF_W-1:0]   upd_sat;
    logic signed [COEF_W-1:0]   kk_sat;
    logic signed [UP_W-1:0]     kk_sq;
    logic                       out_load;

    swar_div_req_t div_req;
    swar_div_rsp_t div_rsp;

    swar_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_WINDOW)
    ) u_hist (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    swar_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // history read address by phase: leaving sample, lag partner, leaving partner
    always_comb
    begin
        case (phase_reg)
            P_LEAVE: ram_raddr = slot_reg - w_reg[HIST_AW-1:0];
            P_BACK:  ram_raddr = slot_reg - HIST_AW'(k_reg);
            P_OTHER: ram_raddr = slot_reg - w_reg[HIST_AW-1:0] + HIST_AW'(k_reg);
            default: ram_raddr = slot_reg;
        endcase
    end

    // single read of the lag sums, scaled by the common shift
    always_comb
    begin
        case (state_reg)
            S_INIT:  lag_idx = '0;
            S_CHK:   lag_idx = m_reg;
            S_NMUL:  lag_idx = m_reg - j_reg;
            default: lag_idx = k_reg;
        endcase
    end

    assign lag_rd = lag_reg[lag_idx];
    assign r_cur  = R_W'($signed(lag_rd) >>> s_reg);

    // coefficient reads
    assign a_idx = (state_reg == S_OUT) ? COEF_IW'(oj_reg) : COEF_IW'(j_reg - 1'b1);
    assign p_idx = COEF_IW'(m_reg - j_reg - 1'b1);
    assign a_rd  = a_reg[a_idx];

    // sliding lag products
    assign p_new   = y_reg * back_reg;
    assign p_old   = leave_reg * other_reg;
    assign lag_abs = lag_rd[LAG_W-1] ? (~lag_rd + 1'b1) : lag_rd;

    // update term, product over 2^16 truncated toward zero
    assign up_trunc = uprod_reg[UP_W-1] ? ((uprod_reg + UP_W'(65535)) >>> Q16)
                                        : (uprod_reg >>> Q16);
    assign upd_diff = 33'(a_rd) - 33'(up_trunc);

    always_comb
    begin
        if (upd_diff > 33'(SAT_POS))
        begin
            upd_sat = SAT_POS;
        end
        else if (upd_diff < 33'(SAT_NEG))
        begin
            upd_sat = SAT_NEG;
        end
        else
        begin
            upd_sat = upd_diff[COEF_W-1:0];
        end
    end

    // reflection coefficient from quotient magnitude and sign
    always_comb
    begin
        if (num_reg[NUM_W-1])
        begin
            if (div_rsp.quo > NUM_W'(8388608))
            begin
                kk_sat = SAT_NEG;
            end
            else
            begin
                kk_sat = -$signed(div_rsp.quo[COEF_W-1:0]);
            end
        end
        else
        begin
            if (div_rsp.quo > NUM_W'(SAT_POS))
            begin
                kk_sat = SAT_POS;
            end
            else
            begin
                kk_sat = div_rsp.quo[COEF_W-1:0];
            end
        end
    end

    assign kk_sq    = kk_reg * kk_reg;
    assign out_load = (state_reg == S_OUT) && (!ovalid_reg || pop);

    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        clr_next    = clr_reg;
        newest_next = newest_reg;
        slot_next   = slot_reg;
        w_next      = w_reg;
        y_next      = y_reg;
        leave_next  = leave_reg;
        back_next   = back_reg;
        other_next  = other_reg;
        k_next      = k_reg;
        lag_next    = lag_reg;
        mag_next    = mag_reg;
        s_next      = s_reg;
        e_next      = e_reg;
        m_next      = m_reg;
        j_next      = j_reg;
        num_next    = num_reg;
        prod_next   = prod_reg;
        kk_next     = kk_reg;
        a_next      = a_reg;
        prev_next   = prev_reg;
        uprod_next  = uprod_reg;
        k2_next     = k2_reg;
        ep_next     = ep_reg;
        sing_next   = sing_reg;
        oj_next     = oj_reg;
        ovalid_next = ovalid_reg;
        ocoef_next  = ocoef_reg;
        oidx_next   = oidx_reg;
        olast_next  = olast_reg;
        osing_next  = osing_reg;
        ram_we      = 1'b0;
        ram_waddr   = slot_reg;
        ram_wdata   = y_reg;
        stat.take   = 1'b0;
        stat.clearing = (state_reg == S_CLEAR);
        div_req.start = 1'b0;
        div_req.mag   = num_reg[NUM_W-1] ? NUM_W'(-num_reg) : NUM_W'(num_reg);
        div_req.den   = e_reg;

        // result word leaves
        if (pop && ovalid_reg)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            // zero the history after reset
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == HIST_AW'(MAX_WINDOW - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            // take the next sample
            S_IDLE:
            begin
                if (item.valid)
                begin
                    stat.take  = 1'b1;
                    y_next     = item.sample;
                    w_next     = window;
                    slot_next  = newest_reg + 1'b1;
                    k_next     = '0;
                    phase_next = P_LEAVE;
                    state_next = S_ISSUE;
                end
            end

            S_ISSUE:
            begin
                state_next = S_CAPT;
            end

            // capture history word
            S_CAPT:
            begin
                case (phase_reg)
                    P_LEAVE:
                    begin
                        leave_next = $signed(ram_rdata);
                        phase_next = P_BACK;
                        state_next = S_ISSUE;
                    end
                    P_BACK:
                    begin
                        back_next  = (k_reg == '0) ? y_reg : $signed(ram_rdata);
                        phase_next = P_OTHER;
                        state_next = S_ISSUE;
                    end
                    default:
                    begin
                        other_next = $signed(ram_rdata);
                        state_next = S_LAG;
                    end
                endcase
            end

            // sliding update of one lag sum
            S_LAG:
            begin
                if (WIN_W'(k_reg) >= w_reg)
                begin
                    lag_next[k_reg] = '0;
                end
                else
                begin
                    lag_next[k_reg] = lag_reg[k_reg] + LAG_W'(p_new) - LAG_W'(p_old);
                end
                k_next = k_reg + 1'b1;
                if (k_reg == LAG_IW'(ORDER))
                begin
                    state_next = S_WRITE;
                end
                else
                begin
                    phase_next = P_BACK;
                    state_next = S_ISSUE;
                end
            end

            S_WRITE:
            begin
                ram_we      = 1'b1;
                newest_next = slot_reg;
                k_next      = '0;
                mag_next    = '0;
                state_next  = S_MAG;
            end

            // largest magnitude over the sums
            S_MAG:
            begin
                if (lag_abs > mag_reg)
                begin
                    mag_next = lag_abs;
                end
                k_next = k_reg + 1'b1;
                if (k_reg == LAG_IW'(ORDER))
                begin
                    s_next     = '0;
                    state_next = S_SHIFT;
                end
            end

            // smallest shift that brings it below the limit
            S_SHIFT:
            begin
                if ((mag_reg >> s_reg) >= MAG_LIMIT)
                begin
                    s_next = s_reg + 1'b1;
                end
                else
                begin
                    state_next = S_INIT;
                end
            end

            S_INIT:
            begin
                e_next    = r_cur;
                for (int i = 0; i < ORDER; i++)
                begin
                    a_next[i]    = '0;
                    prev_next[i] = '0;
                end
                m_next     = LAG_IW'(1);
                sing_next  = 1'b0;
                state_next = S_CHK;
            end

            // order step start: singular test and numerator seed
            S_CHK:
            begin
                j_next = LAG_IW'(1);
                if (e_reg <= 0)
                begin
                    sing_next  = 1'b1;
                    oj_next    = '0;
                    state_next = S_OUT;
                end
                else
                begin
                    num_next   = NUM_W'(r_cur) <<< Q16;
                    state_next = (m_reg == LAG_IW'(1)) ? S_DIVGO : S_NMUL;
                end
            end

            S_NMUL:
            begin
                prod_next  = a_rd * r_cur;
                state_next = S_NACC;
            end

            S_NACC:
            begin
                num_next = num_reg - NUM_W'(prod_reg);
                j_next   = j_reg + 1'b1;
                state_next = ((j_reg + 1'b1) < m_reg) ? S_NMUL : S_DIVGO;
            end

            S_DIVGO:
            begin
                div_req.start = 1'b1;
                state_next    = S_DIVW;
            end

            S_DIVW:
            begin
                if (div_rsp.done)
                begin
                    kk_next    = kk_sat;
                    prev_next  = a_reg;
                    j_next     = LAG_IW'(1);
                    state_next = (m_reg == LAG_IW'(1)) ? S_ASET : S_UMUL;
                end
            end

            S_UMUL:
            begin
                uprod_next = kk_reg * prev_reg[p_idx];
                state_next = S_USUB;
            end

            S_USUB:
            begin
                a_next[a_idx] = upd_sat;
                j_next        = j_reg + 1'b1;
                state_next    = ((j_reg + 1'b1) < m_reg) ? S_UMUL : S_ASET;
            end

            // store reflection, then error update or next order
            S_ASET:
            begin
                a_next[COEF_IW'(m_reg - 1'b1)] = kk_reg;
                if ((kk_reg >= Q16_ONE) || (kk_reg <= -Q16_ONE))
                begin
                    e_next = '0;
                    m_next = m_reg + 1'b1;
                    if (m_reg == LAG_IW'(ORDER))
                    begin
                        oj_next    = '0;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_CHK;
                    end
                end
                else
                begin
                    k2_next    = kk_sq[31:0];
                    state_next = S_E1;
                end
            end

            S_E1:
            begin
                ep_next    = EP_W'($unsigned(e_reg)) * EP_W'(k2_reg);
                state_next = S_E2;
            end

            S_E2:
            begin
                e_next = e_reg - $signed(R_W'(ep_reg >> 32));
                m_next = m_reg + 1'b1;
                if (m_reg == LAG_IW'(ORDER))
                begin
                    oj_next    = '0;
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_CHK;
                end
            end

            // hand out the coefficients one word at a time
            S_OUT:
            begin
                if (out_load)
                begin
                    ovalid_next = 1'b1;
                    ocoef_next  = sing_reg ? '0 : a_rd;
                    oidx_next   = IDX_W'(oj_reg);
                    olast_next  = (oj_reg == LAG_IW'(ORDER - 1));
                    osing_next  = sing_reg;
                    oj_next     = oj_reg + 1'b1;
                    if (oj_reg == LAG_IW'(ORDER - 1))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            phase_reg  <= P_LEAVE;
            clr_reg    <= '0;
            newest_reg <= '0;
            ovalid_reg <= 1'b0;
            for (int i = 0; i <= ORDER; i++)
            begin
                lag_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            clr_reg    <= clr_next;
            newest_reg <= newest_next;
            ovalid_reg <= ovalid_next;
            lag_reg    <= lag_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        slot_reg  <= slot_next;
        w_reg     <= w_next;
        y_reg     <= y_next;
        leave_reg <= leave_next;
        back_reg  <= back_next;
        other_reg <= other_next;
        k_reg     <= k_next;
        mag_reg   <= mag_next;
        s_reg     <= s_next;
        e_reg     <= e_next;
        m_reg     <= m_next;
        j_reg     <= j_next;
        num_reg   <= num_next;
        prod_reg  <= prod_next;
        kk_reg    <= kk_next;
        a_reg     <= a_next;
        prev_reg  <= prev_next;
        uprod_reg <= uprod_next;
        k2_reg    <= k2_next;
        ep_reg    <= ep_next;
        sing_reg  <= sing_next;
        oj_reg    <= oj_next;
        ocoef_reg <= ocoef_next;
        oidx_reg  <= oidx_next;
        olast_reg <= olast_next;
        osing_reg <= osing_next;
    end

    assign ovalid            = ovalid_reg;
    assign coefficient       = ocoef_reg;
    assign coefficient_index = oidx_reg;
    assign last              = olast_reg;
    assign singular          = osing_reg;

endmodule

`default_nettype wire

>>> rtl/sliding_window_ar_model_estimator.sv
`timescale 1ns / 1ps
`default_nettype none

// Sliding-window AR model estimator.
// Samples are pushed through push/full; a word is taken when push is high
// and full is low. Each sample updates lag sums r0..r8 over the last
// window_length samples and yields 8 AR coefficient words (Q7.16,
// saturated) with index, last mark and singular flag.
// Results come out through empty/pop: the oldest word sits on the ports
// while empty is low and leaves when pop is high.
// window_length is written over the APB port at address 0 (clamped to
// 2..1024 when a sample starts); reads return the stored low 11 bits.
// After reset the 1024-word history is swept to zero; full stays high
// during that sweep.
// A solve that turns singular stops early. The one-bit-per-cycle divider
// runs once in each of the 8 order steps, the lag update reads history
// words for each of the 9 lag sums, and the 8 words then leave one per
// cycle while pop is high.
// Two samples can wait in the input queue. If pop stays low, one word holds
// in the output register, the back end waits with the rest of the model,
// and full rises once two more samples are queued.

module sliding_window_ar_model_estimator
    import swar_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [2:0]                 paddr,
    input  wire logic [31:0]                pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    input  wire logic                       push,
    output logic                            full,
    input  wire logic signed [SAMPLE_W-1:0] sample,
    output logic                            empty,
    input  wire logic                       pop,
    output logic signed [COEF_W-1:0]        coefficient,
    output logic [IDX_W-1:0]                coefficient_index,
    output logic                            last,
    output logic                            singular
);

    logic [WIN_W-1:0] wl_reg;
    logic [WIN_W-1:0] win_clamped;
    logic             ovalid;
    swar_item_t       item;
    swar_back_stat_t  stat;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wl_reg <= WIN_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_WINDOW))
        begin
            wl_reg <= pwdata[WIN_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = 32'(wl_reg);

    // window clamp
    always_comb
    begin
        if (wl_reg < WIN_MIN)
        begin
            win_clamped = WIN_MIN;
        end
        else if (wl_reg > WIN_MAX)
        begin
            win_clamped = WIN_MAX;
        end
        else
        begin
            win_clamped = wl_reg;
        end
    end

    swar_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .sample (sample),
        .full   (full),
        .item   (item),
        .stat   (stat)
    );

    swar_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .item              (item),
        .stat              (stat),
        .window            (win_clamped),
        .pop               (pop),
        .ovalid            (ovalid),
        .coefficient       (coefficient),
        .coefficient_index (coefficient_index),
        .last              (last),
        .singular          (singular)
    );

    assign empty = !ovalid;

    // last mark only on the final coefficient
    a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && last) |-> (coefficient_index == IDX_W'(ORDER - 1)))
        else $error("last mark on wrong coefficient");

    // a singular solve gives zero coefficients
    a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && singular) |-> (coefficient == '0))
        else $error("singular word with nonzero coefficient");

    // words of one model follow each other in index order
    a_idx_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && !last) |=>
            (!empty && (coefficient_index == IDX_W'($past(coefficient_index) + 1'b1))))
        else $error("coefficient index out of sequence");

    // no sample taken while the history is swept
    a_clear_full: assert property (@(posedge clk) disable iff (!rst_n)
        stat.clearing |-> (full && !stat.take))
        else $error("sample accepted during history clear");

endmodule

`default_nettype wire

>>> tb/swar_checker.sv
`timescale 1ns / 1ps

module swar_checker
    import swar_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [2:0]                 paddr,
    input  wire logic [31:0]                pwdata,
    input  wire logic                       pready,
    input  wire logic                       push,
    input  wire logic                       full,
    input  wire logic signed [SAMPLE_W-1:0] sample,
    input  wire logic                       empty,
    input  wire logic                       pop,
    input  wire logic signed [COEF_W-1:0]   coefficient,
    input  wire logic [IDX_W-1:0]           coefficient_index,
    input  wire logic                       last,
    input  wire logic                       singular,
    output int                              mismatches,
    output int                              pending
);

    localparam logic [2:0] WIN_ADDR = 3'(4 * int'(REG_WINDOW));

    typedef struct {
        logic signed [COEF_W-1:0] coef;
        logic [IDX_W-1:0]         idx;
        logic                     fin;
        logic                     sing;
    } coef_word_t;

    coef_word_t               coef_words [$];
    logic signed [SAMPLE_W-1:0] hist [MAX_WINDOW];
    logic [LAG_W-1:0]         lags [ORDER+1];
    int unsigned              newest;
    logic [WIN_W-1:0]         win_reg;
    int                       errs;

    assign mismatches = errs;
    assign pending    = coef_words.size();

    function automatic longint sat24(input longint x);
        if (x > 64'sd8388607)
            return 64'sd8388607;
        if (x < -64'sd8388608)
            return -64'sd8388608;
        return x;
    endfunction

    function automatic longint hist_back(input int unsigned slot, input int unsigned age);
        return longint'(hist[(slot + MAX_WINDOW - (age % MAX_WINDOW)) % MAX_WINDOW]);
    endfunction

    // slide the lag sums, then solve the yule-walker system for this sample
    task automatic predict_coefficients(input longint y);
        int unsigned w;
        int unsigned slot;
        longint leave;
        longint back;
        longint other;
        longint mag;
        longint e;
        longint num;
        longint kk;
        longint r [ORDER+1];
        longint a [ORDER];
        longint prev [ORDER];
        int s;
        bit sing;
        coef_word_t word;
        w = win_reg;
        if (w < 2)
            w = 2;
        if (w > MAX_WINDOW)
            w = MAX_WINDOW;
        slot = (newest + 1) % MAX_WINDOW;
        leave = hist_back(slot, w);
        for (int k = 0; k <= ORDER; k++)
        begin
            if (k >= w)
                lags[k] = '0;
            else
            begin
                back  = (k == 0) ? y : hist_back(slot, k);
                other = hist_back(slot, w - k);
                lags[k] = lags[k] + LAG_W'(y * back) - LAG_W'(leave * other);
            end
        end
        hist[slot] = SAMPLE_W'(y);
        newest = slot;

        // normalize so every sum fits in 30 bits of magnitude
        mag = 0;
        for (int k = 0; k <= ORDER; k++)
        begin
            r[k] = longint'($signed(lags[k]));
            if ((r[k] < 0 ? -r[k] : r[k]) > mag)
                mag = (r[k] < 0 ? -r[k] : r[k]);
        end
        s = 0;
        while ((mag >>> s) >= (64'sd1 <<< MAG_LIM_W))
            s++;
        for (int k = 0; k <= ORDER; k++)
            r[k] = r[k] >>> s;

        // levinson-durbin recursion
        for (int j = 0; j < ORDER; j++)
        begin
            a[j] = 0;
            prev[j] = 0;
        end
        sing = 0;
        e = r[0];
        for (int m = 1; m <= ORDER; m++)
        begin
            if (e <= 0)
            begin
                sing = 1;
                break;
            end
            num = r[m] * 65536;
            for (int j = 1; j < m; j++)
                num -= a[j-1] * r[m-j];
            kk = sat24(num / e);
            for (int j = 0; j < m - 1; j++)
                prev[j] = a[j];
            for (int j = 1; j < m; j++)
                a[j-1] = sat24(prev[j-1] - (kk * prev[m-j-1]) / 65536);
            a[m-1] = kk;
            if (kk >= 65536 || kk <= -65536)
                e = 0;
            else
                e -= (e * (kk * kk)) >>> 32;
        end

        for (int j = 0; j < ORDER; j++)
        begin
            word.coef = sing ? '0 : COEF_W'(a[j]);
            word.idx  = IDX_W'(j);
            word.fin  = (j == ORDER - 1);
            word.sing = sing;
            coef_words.push_back(word);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        coef_word_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_WINDOW; i++)
                hist[i] = '0;
            for (int k = 0; k <= ORDER; k++)
                lags[k] = '0;
            newest = 0;
            win_reg = WIN_RESET;
            errs = 0;
            coef_words.delete();
        end
        else
        begin
            // register write snoop
            if (psel && penable && pwrite && pready && paddr == WIN_ADDR)
                win_reg = pwdata[WIN_W-1:0];

            // result word check
            if (pop && !empty)
            begin
                if (coef_words.size() == 0)
                begin
                    errs++;
                    if (errs <= 10)
                        $display("unexpected word: coef %0d idx %0d last %0b singular %0b",
                                 coefficient, coefficient_index, last, singular);
                end
                else
                begin
                    want = coef_words.pop_front();
                    if (want.coef !== coefficient || want.idx !== coefficient_index
                        || want.fin !== last || want.sing !== singular)
                    begin
                        errs++;
                        if (errs <= 10)
                            $display({"word mismatch: exp coef %0d idx %0d last %0b sing %0b,",
                                      " got coef %0d idx %0d last %0b sing %0b"},
                                     want.coef, want.idx, want.fin, want.sing,
                                     coefficient, coefficient_index, last, singular);
                    end
                end
            end

            // sample intake
            if (push && !full)
                predict_coefficients(longint'(sample));
        end
    end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import swar_pkg::*;

    localparam int          STALL_LIMIT = 20000;
    localparam int          SETTLE      = 800;
    localparam logic [2:0]  WIN_ADDR    = 3'(4 * int'(REG_WINDOW));

    logic                       clk;
    logic                       rst_n;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [2:0]                 paddr;
    logic [31:0]                pwdata;
    logic [31:0]                prdata;
    logic                       pready;
    logic                       push;
    logic                       full;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       empty;
    logic                       pop;
    logic signed [COEF_W-1:0]   coefficient;
    logic [IDX_W-1:0]           coefficient_index;
    logic                       last;
    logic                       singular;
    int                         mismatches;
    int                         pending;
    int                         idle_cycles;
    int                         words_taken;
    longint                     ar1;
    longint                     ar2;

    sliding_window_ar_model_estimator dut (.*);

    swar_checker u_checker (.*);

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    initial
    begin
        rst_n   <= 1'b0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        push    <= 1'b0;
        sample  <= '0;
        pop     <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    // watchdog on cycles without any accepted word
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty) || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic int pick_gap();
        if ($urandom_range(0, 3) != 0)
            return 0;
        if ($urandom_range(0, 9) != 0)
            return $urandom_range(1, 4);
        return $urandom_range(20, 300);
    endfunction

    // sample sender
    task automatic send_word(input logic signed [SAMPLE_W-1:0] v);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push   <= 1'b1;
        sample <= v;
        do
            @(posedge clk);
        while (full);
    endtask

    task automatic write_window(input int v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= WIN_ADDR;
        pwdata  <= 32'(v);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] random_sample(input int kind);
        longint v;
        case (kind)
            0: v = $signed(16'($urandom));
            1: v = $signed(16'($urandom_range(0, 16))) - 8;
            2:
            begin
                // noisy second-order resonance
                v = ar1 + (ar1 * 3) / 4 - ar2 / 2 + (int'($urandom_range(0, 4000)) - 2000);
                if (v > 32767)
                    v = 32767;
                if (v < -32768)
                    v = -32768;
                ar2 = ar1;
                ar1 = v;
            end
            default:
            begin
                case ($urandom_range(0, 2))
                    0: v = 32767;
                    1: v = -32768;
                    default: v = 0;
                endcase
            end
        endcase
        return SAMPLE_W'(v);
    endfunction

    // result reader, with one long hold-off to back the block up
    initial
    begin
        int gap;
        words_taken = 0;
        @(posedge rst_n);
        forever
        begin
            gap = pick_gap();
            if (words_taken == 160)
                gap = 6000;
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            do
                @(posedge clk);
            while (empty);
            words_taken++;
        end
    end

    // stimulus and verdict
    initial
    begin
        int windows [10];
        int kind;
        windows = '{0, 2, 3, 9, 1024, 2047, 17, 100, 256, 5};
        ar1 = 0;
        ar2 = 0;
        @(posedge rst_n);
        @(posedge clk);

        // directed: zero history, extremes, sign flips
        send_word(16'sd0);
        send_word(16'sd0);
        send_word(16'sd32767);
        send_word(-16'sd32768);
        send_word(16'sd32767);
        send_word(-16'sd32768);
        send_word(16'sd1);
        send_word(-16'sd1);
        for (int i = 0; i < 6; i++)
            send_word(16'sd32767);
        for (int i = 0; i < 6; i++)
            send_word(-16'sd32768);
        drain();

        // window of one lag only, then a changed window midstream
        write_window(2);
        send_word(16'sd32767);
        send_word(-16'sd32768);
        send_word(16'sd5);
        drain();
        write_window(1024);
        send_word(16'sd100);
        drain();

        // random phases across window settings
        foreach (windows[p])
        begin
            write_window(windows[p]);
            kind = $urandom_range(0, 3);
            for (int i = 0; i < 33; i++)
            begin
                if ($urandom_range(0, 4) == 0)
                    kind = $urandom_range(0, 3);
                send_word(random_sample(kind));
            end
            drain();
        end

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
